// ===== hw/rtl/char_lcd_nibble_interface_core_macros.svh =====
// Assertion macros used by the display interface checker
`ifndef CHAR_LCD_NIBBLE_INTERFACE_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CLNI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define CLNI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/clni_pkg.sv =====
// Types and constants of the character display nibble interface
package clni_pkg;

    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    // request codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_COMMAND = 3'd1;
    localparam logic [2:0] OP_DATA    = 3'd2;
    localparam logic [2:0] OP_CURSOR  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_HOME    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BOOT_WAIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_RESET  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_RESET = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_HOME  = 3'd6;

    // register reset values
    localparam logic [19:0] RST_BOOT_WAIT   = 20'd15000;
    localparam logic [19:0] RST_LONG_RESET  = 20'd5000;
    localparam logic [19:0] RST_SHORT_RESET = 20'd1000;
    localparam logic [7:0]  RST_ENABLE      = 8'd20;
    localparam logic [15:0] RST_COMMAND     = 16'd42;
    localparam logic [15:0] RST_DATA        = 16'd46;
    localparam logic [19:0] RST_CLEAR_HOME  = 20'd2000;

    // controller bytes and nibbles
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] ROW0_OFFSET      = 8'h00;
    localparam logic [7:0] ROW1_OFFSET      = 8'h40;
    localparam logic [3:0] NIB_SOFT_RESET   = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

    typedef enum logic [4:0] {
        S_BOOT       = 5'd0,
        S_RST1_EN    = 5'd1,
        S_RST1_WAIT  = 5'd2,
        S_RST2_EN    = 5'd3,
        S_RST2_WAIT  = 5'd4,
        S_RST3_EN    = 5'd5,
        S_RST3_WAIT  = 5'd6,
        S_MODE_EN    = 5'd7,
        S_MODE_WAIT  = 5'd8,
        S_FUNC_HI    = 5'd9,
        S_FUNC_GAP   = 5'd10,
        S_FUNC_LO    = 5'd11,
        S_FUNC_WAIT  = 5'd12,
        S_DISP_HI    = 5'd13,
        S_DISP_GAP   = 5'd14,
        S_DISP_LO    = 5'd15,
        S_DISP_WAIT  = 5'd16,
        S_ENTRY_HI   = 5'd17,
        S_ENTRY_GAP  = 5'd18,
        S_ENTRY_LO   = 5'd19,
        S_ENTRY_WAIT = 5'd20,
        S_BYTE_HI    = 5'd21,
        S_BYTE_GAP   = 5'd22,
        S_BYTE_LO    = 5'd23,
        S_BYTE_WAIT  = 5'd24,
        S_LONG_WAIT  = 5'd25,
        S_IDLE       = 5'd26
    } step_t;

    typedef struct packed {
        logic [19:0] boot_wait_ticks;
        logic [19:0] long_reset_ticks;
        logic [19:0] short_reset_ticks;
        logic [7:0]  enable_ticks;
        logic [15:0] command_ticks;
        logic [15:0] data_ticks;
        logic [19:0] clear_home_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic [5:0] column;
        logic       row;
    } item_t;

    typedef struct packed {
        logic [3:0] pin_nibble;
        logic       pin_select;
        logic       pin_enable;
        logic       busy_res;
        logic       rejected;
    } result_t;

endpackage

// ===== hw/rtl/clni_if.sv =====
// Request and result channel interfaces of the display interface
interface clni_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] value;
    logic [5:0] column;
    logic       row;

    modport source (output valid, output op, output value, output column, output row,
                    input ready);
    modport sink   (input valid, input op, input value, input column, input row,
                    output ready);
endinterface

interface clni_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] pin_nibble;
    logic       pin_select;
    logic       pin_enable;
    logic       busy_res;
    logic       rejected;

    modport source (output valid, output pin_nibble, output pin_select, output pin_enable,
                    output busy_res, output rejected, input ready);
    modport sink   (input valid, input pin_nibble, input pin_select, input pin_enable,
                    input busy_res, input rejected, output ready);
endinterface

// ===== hw/rtl/char_lcd_nibble_interface_core.sv =====
// Top level of the character display 4-bit bus interface
//
//   port   direction  carries
//   req    in         op, value, column, row (one tick or request per beat)
//   res    out        pin_nibble, pin_select, pin_enable, busy_res, rejected
//   cfg    in         cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle sustained while the result is not stalled; a beat's result
// passes the input register, then the sequencer step into the result register,
// from which it is offered.
// The sequencer advances its step and wait timer once per beat while busy.
// Reset starts the boot wait of the init sequence; the timer is WAIT_BITS wide.
// A stalled result holds the result register and then the input register.
module char_lcd_nibble_interface_core #(
    parameter int WAIT_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    clni_req_if.sink                            req,
    clni_res_if.source                          res,
    input  logic                                cfg_we,
    input  logic [clni_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [clni_pkg::CFG_DATA_W-1:0]     cfg_data
);

    clni_pkg::cfg_t     cfg;
    clni_pkg::item_t    item_reg;
    clni_pkg::result_t  step_result;
    clni_pkg::result_t  out_reg;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    assign in_valid_next  = (req.valid && req.ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance || (out_valid_reg && !res.ready);

    clni_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clni_seq #(
        .WAIT_BITS (WAIT_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: load on their beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.op     <= req.op;
            item_reg.value  <= req.value;
            item_reg.column <= req.column;
            item_reg.row    <= req.row;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.pin_nibble = out_reg.pin_nibble;
    assign res.pin_select = out_reg.pin_select;
    assign res.pin_enable = out_reg.pin_enable;
    assign res.busy_res   = out_reg.busy_res;
    assign res.rejected   = out_reg.rejected;

endmodule

// ===== hw/rtl/clni_cfg.sv =====
// Configuration register file of the display interface
module clni_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [clni_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [clni_pkg::CFG_DATA_W-1:0]     cfg_data,
    output clni_pkg::cfg_t                      cfg
);

    clni_pkg::cfg_t cfg_reg;
    clni_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                clni_pkg::REG_BOOT_WAIT:   cfg_next.boot_wait_ticks   = cfg_data[19:0];
                clni_pkg::REG_LONG_RESET:  cfg_next.long_reset_ticks  = cfg_data[19:0];
                clni_pkg::REG_SHORT_RESET: cfg_next.short_reset_ticks = cfg_data[19:0];
                clni_pkg::REG_ENABLE:      cfg_next.enable_ticks      = cfg_data[7:0];
                clni_pkg::REG_COMMAND:     cfg_next.command_ticks     = cfg_data[15:0];
                clni_pkg::REG_DATA:        cfg_next.data_ticks        = cfg_data[15:0];
                clni_pkg::REG_CLEAR_HOME:  cfg_next.clear_home_ticks  = cfg_data[19:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boot_wait_ticks   <= clni_pkg::RST_BOOT_WAIT;
            cfg_reg.long_reset_ticks  <= clni_pkg::RST_LONG_RESET;
            cfg_reg.short_reset_ticks <= clni_pkg::RST_SHORT_RESET;
            cfg_reg.enable_ticks      <= clni_pkg::RST_ENABLE;
            cfg_reg.command_ticks     <= clni_pkg::RST_COMMAND;
            cfg_reg.data_ticks        <= clni_pkg::RST_DATA;
            cfg_reg.clear_home_ticks  <= clni_pkg::RST_CLEAR_HOME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/clni_seq.sv =====
// Init and transfer sequencer: step, wait timer and pin levels
module clni_seq #(
    parameter int WAIT_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  clni_pkg::item_t     item,
    input  clni_pkg::cfg_t      cfg,
    output clni_pkg::result_t   result
);

    localparam int CW = (WAIT_BITS > clni_pkg::CFG_DATA_W) ? WAIT_BITS : clni_pkg::CFG_DATA_W;
    localparam logic [CW-1:0] WAIT_MAX = CW'((64'd1 << WAIT_BITS) - 64'd1);

    clni_pkg::step_t         step_reg, step_next, target;
    logic [WAIT_BITS-1:0]    wait_reg, wait_next, wait_inc;
    logic [7:0]              byte_reg, byte_next;
    logic                    select_reg, select_next;
    logic                    long_reg, long_next;
    logic [3:0]              nibble_reg, nibble_next;
    logic                    enable_reg, enable_next;
    logic [clni_pkg::CFG_DATA_W-1:0] dur_raw;
    logic [CW-1:0]           dur_ext, dur_lim;
    logic                    done, request, idle, rejected;
    logic [7:0]              cursor_byte;

    assign idle    = (step_reg == clni_pkg::S_IDLE);
    assign request = (item.op >= clni_pkg::OP_COMMAND) && (item.op <= clni_pkg::OP_HOME);
    assign cursor_byte = clni_pkg::CMD_SET_DDRAM
                       + (item.row ? clni_pkg::ROW1_OFFSET : clni_pkg::ROW0_OFFSET)
                       + {2'b00, item.column};

    // duration of the current step
    always_comb
    begin
        case (step_reg)
            clni_pkg::S_BOOT:
                dur_raw = cfg.boot_wait_ticks;
            clni_pkg::S_RST1_EN, clni_pkg::S_RST2_EN, clni_pkg::S_RST3_EN,
            clni_pkg::S_MODE_EN,
            clni_pkg::S_FUNC_HI, clni_pkg::S_FUNC_LO, clni_pkg::S_DISP_HI,
            clni_pkg::S_DISP_LO, clni_pkg::S_ENTRY_HI, clni_pkg::S_ENTRY_LO,
            clni_pkg::S_BYTE_HI, clni_pkg::S_BYTE_LO:
                dur_raw = {12'd0, cfg.enable_ticks};
            clni_pkg::S_RST1_WAIT, clni_pkg::S_MODE_WAIT:
                dur_raw = cfg.long_reset_ticks;
            clni_pkg::S_RST2_WAIT, clni_pkg::S_RST3_WAIT:
                dur_raw = cfg.short_reset_ticks;
            clni_pkg::S_FUNC_GAP, clni_pkg::S_DISP_GAP, clni_pkg::S_ENTRY_GAP,
            clni_pkg::S_BYTE_GAP:
                dur_raw = clni_pkg::CFG_DATA_W'(1);
            clni_pkg::S_FUNC_WAIT, clni_pkg::S_DISP_WAIT, clni_pkg::S_ENTRY_WAIT,
            clni_pkg::S_BYTE_WAIT:
                dur_raw = {4'd0, select_reg ? cfg.data_ticks : cfg.command_ticks};
            clni_pkg::S_LONG_WAIT:
                dur_raw = cfg.clear_home_ticks;
            default:
                dur_raw = '0;
        endcase
    end

    assign dur_ext  = CW'(dur_raw);
    assign dur_lim  = (dur_ext > WAIT_MAX) ? WAIT_MAX : dur_ext;
    assign wait_inc = wait_reg + {{(WAIT_BITS-1){1'b0}}, 1'b1};
    assign done     = (CW'(wait_inc) >= dur_lim);

    always_comb
    begin
        step_next   = step_reg;
        wait_next   = wait_reg;
        byte_next   = byte_reg;
        select_next = select_reg;
        long_next   = long_reg;
        nibble_next = nibble_reg;
        enable_next = enable_reg;
        target      = step_reg;
        rejected    = 1'b0;

        if (step_en)
        begin
            if (idle && request)
            begin
                select_next = (item.op == clni_pkg::OP_DATA);
                long_next   = (item.op == clni_pkg::OP_CLEAR) || (item.op == clni_pkg::OP_HOME);
                case (item.op)
                    clni_pkg::OP_COMMAND, clni_pkg::OP_DATA: byte_next = item.value;
                    clni_pkg::OP_CURSOR: byte_next = cursor_byte;
                    clni_pkg::OP_CLEAR:  byte_next = clni_pkg::CMD_CLEAR;
                    default:             byte_next = clni_pkg::CMD_HOME;
                endcase
                step_next   = clni_pkg::S_BYTE_HI;
                wait_next   = '0;
                nibble_next = byte_next[7:4];
                enable_next = 1'b1;
            end
            else
            begin
                rejected = request;
                if (!idle)
                begin
                    wait_next = wait_inc;
                    if (done)
                    begin
                        case (step_reg)
                            clni_pkg::S_ENTRY_WAIT:
                            begin
                                // init ends with a clear and its long wait
                                target      = clni_pkg::S_BYTE_HI;
                                byte_next   = clni_pkg::CMD_CLEAR;
                                select_next = 1'b0;
                                long_next   = 1'b1;
                            end
                            clni_pkg::S_BYTE_WAIT:
                                target = long_reg ? clni_pkg::S_LONG_WAIT : clni_pkg::S_IDLE;
                            clni_pkg::S_LONG_WAIT, clni_pkg::S_IDLE:
                                target = clni_pkg::S_IDLE;
                            default:
                                target = clni_pkg::step_t'(5'(step_reg + 5'd1));
                        endcase

                        step_next = target;
                        wait_next = '0;
                        case (target)
                            clni_pkg::S_RST1_EN, clni_pkg::S_RST2_EN, clni_pkg::S_RST3_EN:
                            begin
                                nibble_next = clni_pkg::NIB_SOFT_RESET;
                                enable_next = 1'b1;
                            end
                            clni_pkg::S_MODE_EN:
                            begin
                                nibble_next = clni_pkg::NIB_FOUR_BIT;
                                enable_next = 1'b1;
                            end
                            clni_pkg::S_FUNC_HI, clni_pkg::S_DISP_HI, clni_pkg::S_ENTRY_HI:
                            begin
                                case (target)
                                    clni_pkg::S_FUNC_HI: byte_next = clni_pkg::CMD_FUNCTION_SET;
                                    clni_pkg::S_DISP_HI: byte_next = clni_pkg::CMD_DISPLAY_ON;
                                    default:             byte_next = clni_pkg::CMD_ENTRY_MODE;
                                endcase
                                select_next = 1'b0;
                                long_next   = 1'b0;
                                nibble_next = byte_next[7:4];
                                enable_next = 1'b1;
                            end
                            clni_pkg::S_BYTE_HI:
                            begin
                                nibble_next = byte_next[7:4];
                                enable_next = 1'b1;
                            end
                            clni_pkg::S_FUNC_LO, clni_pkg::S_DISP_LO, clni_pkg::S_ENTRY_LO,
                            clni_pkg::S_BYTE_LO:
                            begin
                                nibble_next = byte_reg[3:0];
                                enable_next = 1'b1;
                            end
                            default:
                                enable_next = 1'b0;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= clni_pkg::S_BOOT;
            wait_reg   <= '0;
            byte_reg   <= '0;
            select_reg <= 1'b0;
            long_reg   <= 1'b0;
            nibble_reg <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            wait_reg   <= wait_next;
            byte_reg   <= byte_next;
            select_reg <= select_next;
            long_reg   <= long_next;
            nibble_reg <= nibble_next;
            enable_reg <= enable_next;
        end
    end

    assign result.pin_nibble = nibble_next;
    assign result.pin_select = select_next;
    assign result.pin_enable = enable_next;
    assign result.busy_res   = (step_next != clni_pkg::S_IDLE);
    assign result.rejected   = rejected;

endmodule

// ===== hw/rtl/clni_checker.sv =====
// Port-level checker for the display interface, bound to the top level
`include "char_lcd_nibble_interface_core_macros.svh"

module clni_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [3:0] res_pin_nibble,
    input logic       res_pin_enable,
    input logic       res_busy_res
);

    // a stalled result beat stays and holds its pins
    `CLNI_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_pin_nibble) && $stable(res_pin_enable), "stalled result beat changed")

    // the enable strobe only rises inside a transfer
    `CLNI_ASSERT_NOW(a_enable_busy, clk, rst_n, res_valid && res_pin_enable, res_busy_res, "enable high while idle")

    // requests are only held off by a stalled result
    `CLNI_ASSERT_NOW(a_ready_stall, clk, rst_n, !req_ready, res_valid && !res_ready, "request stalled without output back-pressure")

endmodule

bind char_lcd_nibble_interface_core clni_checker u_clni_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ready      (req.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_pin_nibble (res.pin_nibble),
    .res_pin_enable (res.pin_enable),
    .res_busy_res   (res.busy_res)
);
